>>> rtl/aesc_pkg.sv
// Shared types, constants and the AES S-box for the counter-mode stream cipher.
// No dependencies; aesc_front, aesc_keyexp, aesc_core and the top level import this package.
package aesc_pkg;

    // Number of IV bytes at the top of the counter block; the rest is the counter.
    localparam int IV_BYTES = 12;
    localparam int CTR_BITS = (16 - IV_BYTES) * 8;
    localparam logic [63:0] CTR_MASK = (CTR_BITS >= 64) ? {64{1'b1}} :
                                       ((64'd1 << CTR_BITS) - 64'd1);

    // Round key storage: four banks, one per column, one row per round.
    localparam int RK_ROWS  = 15;
    localparam int RK_AW    = $clog2(RK_ROWS);

    // Configuration register indexes.
    localparam logic [2:0] REG_KEY0     = 3'd0;
    localparam logic [2:0] REG_KEY1     = 3'd1;
    localparam logic [2:0] REG_KEY2     = 3'd2;
    localparam logic [2:0] REG_KEY3     = 3'd3;
    localparam logic [2:0] REG_KEY_SIZE = 3'd4;
    localparam logic [2:0] REG_ENABLE   = 3'd5;

    // Key size codes.
    localparam logic [1:0] KS_128 = 2'd0;
    localparam logic [1:0] KS_192 = 2'd1;

    // Input item kinds.
    localparam logic KIND_START = 1'b0;

    typedef struct packed {
        logic        kind;
        logic [63:0] iv_high;
        logic [31:0] iv_low;
        logic [7:0]  data_byte;
        logic        last_in;
    } t_item;

    // Round key write port from the expansion sequencer to the storage banks.
    typedef struct packed {
        logic             we;
        logic [1:0]       bank;
        logic [RK_AW-1:0] addr;
        logic [31:0]      data;
    } t_rk_wr;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_KEY0,
        CS_ROUND
    } t_core_state;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sub_byte(input logic [7:0] x);
        return SBOX[x];
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sub_byte(w[31:24]), sub_byte(w[23:16]), sub_byte(w[15:8]), sub_byte(w[7:0])};
    endfunction

    // Number of rounds; any code other than 128 or 192 is treated as a 256-bit key.
    function automatic logic [3:0] num_rounds(input logic [1:0] ks);
        logic [3:0] nr;
        case (ks)
            KS_128:  nr = 4'd10;
            KS_192:  nr = 4'd12;
            default: nr = 4'd14;
        endcase
        return nr;
    endfunction

endpackage

>>> rtl/aesc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module aesc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/aesc_front.sv
// Front end: accepts input transactions and holds them in a two-entry queue.
// Depends on aesc_pkg for the item type.
module aesc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  aesc_pkg::t_item i_item,
    output logic            o_q_valid,
    output aesc_pkg::t_item o_q_item,
    input  logic            i_pop
);
    import aesc_pkg::*;

    t_item      r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready   = (r_cnt != 2'd2);
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rp];
    assign push      = i_valid && o_ready;
    assign pop       = i_pop && o_q_valid;

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= i_item;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

>>> rtl/aesc_keyexp.sv
// Key expansion sequencer: produces one round key word per cycle into the key banks.
// Depends on aesc_pkg for the S-box and the write port type.
module aesc_keyexp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_restart,
    input  logic [3:0][63:0]      i_key,
    input  logic [1:0]            i_key_size,
    output aesc_pkg::t_rk_wr      o_wr,
    output logic                  o_busy
);
    import aesc_pkg::*;

    logic        r_busy;
    logic [5:0]  r_i;
    logic [2:0]  r_kmod;
    logic [3:0]  r_rci;
    logic [31:0] r_win [8];

    logic [3:0]  nk;
    logic [2:0]  nk_m1;
    logic [5:0]  total_m1;
    logic        in_key;
    logic [63:0] kw;
    logic [31:0] back, t, w;
    logic [7:0]  rc;

    // Next word of the schedule.
    always_comb begin
        case (i_key_size)
            KS_128:  begin nk = 4'd4; total_m1 = 6'd43; end
            KS_192:  begin nk = 4'd6; total_m1 = 6'd51; end
            default: begin nk = 4'd8; total_m1 = 6'd59; end
        endcase
        nk_m1  = 3'(nk - 4'd1);
        in_key = (r_i < {2'b00, nk});
        kw     = i_key[r_i[2:1]];
        case (nk_m1)
            3'd3:    back = r_win[3];
            3'd5:    back = r_win[5];
            default: back = r_win[7];
        endcase
        case (r_rci)
            4'd0:    rc = 8'h01;
            4'd1:    rc = 8'h02;
            4'd2:    rc = 8'h04;
            4'd3:    rc = 8'h08;
            4'd4:    rc = 8'h10;
            4'd5:    rc = 8'h20;
            4'd6:    rc = 8'h40;
            4'd7:    rc = 8'h80;
            4'd8:    rc = 8'h1b;
            default: rc = 8'h36;
        endcase
        t = r_win[0];
        if (r_kmod == 3'd0) begin
            t = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'd0};
        end else if (nk == 4'd8 && r_kmod == 3'd4) begin
            t = sub_word(t);
        end
        w = in_key ? (r_i[0] ? kw[31:0] : kw[63:32]) : (back ^ t);
    end

    assign o_wr.we   = r_busy;
    assign o_wr.bank = r_i[1:0];
    assign o_wr.addr = RK_AW'(r_i[5:2]);
    assign o_wr.data = w;
    assign o_busy    = r_busy;

    // Window of the last eight words.
    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_win[0] <= w;
            for (int k = 1; k < 8; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end
    end

    // Sequencer control; reset starts an expansion of the zero key.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_restart) begin
            r_busy <= 1'b1;
            r_i    <= 6'd0;
            r_kmod <= 3'd0;
            r_rci  <= 4'd0;
        end else if (r_busy) begin
            r_i    <= r_i + 6'd1;
            r_kmod <= (r_kmod == nk_m1) ? 3'd0 : r_kmod + 3'd1;
            if (!in_key && r_kmod == 3'd0) begin
                r_rci <= r_rci + 4'd1;
            end
            if (r_i == total_m1) begin
                r_busy <= 1'b0;
            end
        end
    end
endmodule

>>> rtl/aesc_core.sv
// Back end: counter block state, iterative AES rounds and the output register.
// Depends on aesc_pkg for types, constants and the S-box.
module aesc_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  aesc_pkg::t_item           i_q_item,
    output logic                      o_pop,
    input  logic                      i_kx_busy,
    input  logic                      i_enable,
    input  logic [1:0]                i_key_size,
    output logic [aesc_pkg::RK_AW-1:0] o_rk_addr,
    input  logic [127:0]              i_rk,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [7:0]                o_byte,
    output logic                      o_last,
    output logic                      o_status
);
    import aesc_pkg::*;

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    // One AES round including the round key; the final round skips MixColumns.
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic [127:0] rk,
                                               input logic fin);
        logic [7:0]   b [16];
        logic [7:0]   t [16];
        logic [7:0]   m [16];
        logic [7:0]   all;
        logic [127:0] o;
        for (int i = 0; i < 16; i++) begin
            b[i] = sub_byte(s[127-8*i -: 8]);
        end
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[4*c+i] = b[4*((c+i)%4)+i];
            end
        end
        for (int c = 0; c < 4; c++) begin
            all = t[4*c] ^ t[4*c+1] ^ t[4*c+2] ^ t[4*c+3];
            m[4*c]   = t[4*c]   ^ all ^ xtime(t[4*c]   ^ t[4*c+1]);
            m[4*c+1] = t[4*c+1] ^ all ^ xtime(t[4*c+1] ^ t[4*c+2]);
            m[4*c+2] = t[4*c+2] ^ all ^ xtime(t[4*c+2] ^ t[4*c+3]);
            m[4*c+3] = t[4*c+3] ^ all ^ xtime(t[4*c+3] ^ t[4*c]);
        end
        for (int i = 0; i < 16; i++) begin
            o[127-8*i -: 8] = fin ? t[i] : m[i];
        end
        return o ^ rk;
    endfunction

    t_core_state r_st, n_st;
    logic [63:0]  r_cu, n_cu;
    logic [63:0]  r_clo, n_clo;
    logic [127:0] r_ks, n_ks;
    logic         r_ksok, n_ksok;
    logic [3:0]   r_pos, n_pos;
    logic [127:0] r_aes, n_aes;
    logic [3:0]   r_rnd, n_rnd;
    logic         r_ov, n_ov;
    logic [7:0]   r_ob, n_ob;
    logic         r_ol, n_ol;
    logic         r_os, n_os;

    logic [3:0]   nr;
    logic         out_free;
    logic [7:0]   ks_byte;
    logic [127:0] rnd_out;

    assign nr       = num_rounds(i_key_size);
    assign out_free = !r_ov || i_ready;
    assign ks_byte  = r_ks[{~r_pos, 3'b000} +: 8];
    assign rnd_out  = aes_round(r_aes, i_rk, r_rnd == nr);

    // Next state and datapath control.
    always_comb begin
        n_st      = r_st;
        n_cu      = r_cu;
        n_clo     = r_clo;
        n_ks      = r_ks;
        n_ksok    = r_ksok;
        n_pos     = r_pos;
        n_aes     = r_aes;
        n_rnd     = r_rnd;
        n_ov      = r_ov && !i_ready;
        n_ob      = r_ob;
        n_ol      = r_ol;
        n_os      = r_os;
        o_pop     = 1'b0;
        o_rk_addr = '0;
        unique case (r_st)
            CS_IDLE: begin
                if (i_q_valid && !i_kx_busy) begin
                    if (i_q_item.kind == KIND_START) begin
                        n_cu  = i_q_item.iv_high;
                        n_clo = {i_q_item.iv_low, 32'd0} & ~CTR_MASK;
                        n_pos = 4'd0;
                        o_pop = 1'b1;
                    end else if (!i_enable) begin
                        if (out_free) begin
                            n_ov  = 1'b1;
                            n_ob  = 8'd0;
                            n_ol  = i_q_item.last_in;
                            n_os  = 1'b1;
                            o_pop = 1'b1;
                        end
                    end else if (r_pos == 4'd0 && !r_ksok) begin
                        n_st = CS_KEY0;
                    end else if (out_free) begin
                        n_ov   = 1'b1;
                        n_ob   = i_q_item.data_byte ^ ks_byte;
                        n_ol   = i_q_item.last_in;
                        n_os   = 1'b0;
                        o_pop  = 1'b1;
                        n_ksok = 1'b0;
                        n_pos  = r_pos + 4'd1;
                        if (r_pos == 4'd15) begin
                            n_clo = (r_clo & ~CTR_MASK) | ((r_clo + 64'd1) & CTR_MASK);
                        end
                    end
                end
            end
            CS_KEY0: begin
                n_aes     = {r_cu, r_clo} ^ i_rk;
                n_rnd     = 4'd1;
                o_rk_addr = RK_AW'(1);
                n_st      = CS_ROUND;
            end
            CS_ROUND: begin
                n_aes = rnd_out;
                if (r_rnd == nr) begin
                    n_ks   = rnd_out;
                    n_ksok = 1'b1;
                    n_st   = CS_IDLE;
                end else begin
                    n_rnd     = r_rnd + 4'd1;
                    o_rk_addr = RK_AW'(r_rnd + 4'd1);
                end
            end
            default: n_st = CS_IDLE;
        endcase
    end

    // State register and payload registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= CS_IDLE;
            r_cu   <= '0;
            r_clo  <= '0;
            r_ks   <= '0;
            r_ksok <= 1'b0;
            r_pos  <= 4'd0;
            r_ov   <= 1'b0;
        end else begin
            r_st   <= n_st;
            r_cu   <= n_cu;
            r_clo  <= n_clo;
            r_ks   <= n_ks;
            r_ksok <= n_ksok;
            r_pos  <= n_pos;
            r_ov   <= n_ov;
        end
        r_aes <= n_aes;
        r_rnd <= n_rnd;
        r_ob  <= n_ob;
        r_ol  <= n_ol;
        r_os  <= n_os;
    end

    assign o_valid  = r_ov;
    assign o_byte   = r_ob;
    assign o_last   = r_ol;
    assign o_status = r_os;
endmodule

>>> rtl/aes_ctr_stream_cipher_unit.sv
// Top level of the AES counter-mode stream cipher: register port, queue, key schedule, core.
// Depends on aesc_pkg, aesc_ram, aesc_front, aesc_keyexp and aesc_core.
//
//  Channel  | Signals                        | Contents
//  ---------+--------------------------------+------------------------------------------
//  input    | i_s_tvalid/o_s_tready          | tdata iv_high, iv_low, data_byte; tuser kind;
//           |                                | tlast last_in
//  output   | o_m_tvalid/i_m_tready          | tdata out_byte; tuser status; tlast out_last
//  config   | psel/penable/pwrite/paddr      | six registers at byte address 8*i, 64 bits
//
// A data byte is taken once its keystream byte is ready and the output register is free;
// the first byte of each 16-byte block first waits for the round loop, one round per
// cycle. Writing a key or key_size register runs the key schedule, one word per cycle
// (44, 52 or 60 words); the core waits for it. Reset also runs it.
// The two-entry input queue and the output register let either side stall on its own.
module aes_ctr_stream_cipher_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [103:0] i_s_tdata,   // [63:0] iv_high, [95:64] iv_low, [103:96] data_byte
    input  logic         i_s_tuser,   // [0] kind
    input  logic         i_s_tlast,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [7:0]   o_m_tdata,   // [7:0] out_byte
    output logic         o_m_tuser,   // [0] status
    output logic         o_m_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);
    import aesc_pkg::*;

    logic [3:0][63:0] r_key;
    logic [1:0]       r_key_size;
    logic             r_enable;
    logic             wr_en;
    logic [2:0]       reg_idx;
    logic             kx_restart;

    t_item            s_item, q_item;
    logic             q_valid, q_pop;
    t_rk_wr           rk_wr;
    logic             kx_busy;
    logic [RK_AW-1:0] rk_addr;
    logic [127:0]     rk_row;

    // Register port decode.
    assign pready     = 1'b1;
    assign reg_idx    = paddr[5:3];
    assign wr_en      = psel && penable && pwrite;
    assign kx_restart = wr_en && (reg_idx <= REG_KEY_SIZE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key      <= '0;
            r_key_size <= KS_128;
            r_enable   <= 1'b0;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: r_key[reg_idx[1:0]] <= pwdata;
                REG_KEY_SIZE: r_key_size <= pwdata[1:0];
                REG_ENABLE:   r_enable   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: prdata = r_key[reg_idx[1:0]];
            REG_KEY_SIZE: prdata = {62'd0, r_key_size};
            REG_ENABLE:   prdata = {63'd0, r_enable};
            default:      prdata = '0;
        endcase
    end

    // Input field unpacking.
    assign s_item.kind      = i_s_tuser;
    assign s_item.iv_high   = i_s_tdata[63:0];
    assign s_item.iv_low    = i_s_tdata[95:64];
    assign s_item.data_byte = i_s_tdata[103:96];
    assign s_item.last_in   = i_s_tlast;

    aesc_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_item    (s_item),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_pop     (q_pop)
    );

    aesc_keyexp u_keyexp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_restart  (kx_restart),
        .i_key      (r_key),
        .i_key_size (r_key_size),
        .o_wr       (rk_wr),
        .o_busy     (kx_busy)
    );

    // One bank per round key column; bank 0 holds the most significant word.
    for (genvar g = 0; g < 4; g++) begin : g_bank
        aesc_ram #(
            .WIDTH (32),
            .DEPTH (RK_ROWS)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (rk_wr.we && (rk_wr.bank == 2'(g))),
            .i_waddr (rk_wr.addr),
            .i_wdata (rk_wr.data),
            .i_raddr (rk_addr),
            .o_rdata (rk_row[127-32*g -: 32])
        );
    end

    aesc_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_item   (q_item),
        .o_pop      (q_pop),
        .i_kx_busy  (kx_busy),
        .i_enable   (r_enable),
        .i_key_size (r_key_size),
        .o_rk_addr  (rk_addr),
        .i_rk       (rk_row),
        .o_valid    (o_m_tvalid),
        .i_ready    (i_m_tready),
        .o_byte     (o_m_tdata),
        .o_last     (o_m_tlast),
        .o_status   (o_m_tuser)
    );
endmodule
